// ===== rtl/rws_pkg.sv =====
// shared types and constants for the roulette wheel selection core
package rws_pkg;

	localparam int FIT_W      = 32;
	localparam int POP_CNT_W  = 9;
	localparam int IDX_OUT_W  = 8;
	localparam int RAND_IN_W  = 16;

	// item kind codes
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SELECT = 1'b1;

	typedef struct packed {
		logic                        kind;
		logic [IDX_OUT_W-1:0]        entry_index;
		logic signed [FIT_W-1:0]     fitness_value;
		logic [RAND_IN_W-1:0]        random_fraction;
	} in_item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]        selected_index;
		logic                        empty_error;
	} out_item_t;

	// fitness write broadcast to every cell
	typedef struct packed {
		logic                        en;
		logic [IDX_OUT_W-1:0]        idx;
		logic [FIT_W-1:0]            data;
	} wr_bcast_t;

endpackage

// ===== rtl/roulette_wheel_select_core.sv =====
// roulette wheel selection core: control sequencer and a row of fitness cells
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | into core | in_valid / in_stall  | in_data  (kind, index, fitness, fraction)
//  out     | from core | out_valid / out_stall| out_data (selected index, empty flag)
//  cfg     | into core | cfg_wr_en            | cfg_wr_data (population count)
//
// write item: the input does not stall, and the next item is taken in the following cycle
// select item: input stalled through the sum wave along the row, the low and high multiplier
// steps, the point add, the scan wave and the result and output register loads
// select on an empty population: input stalled while the core goes straight to its done state
// a result held by out_stall keeps the core in its done state until the output frees
// reset clears control state and the population count; fitness entries are undefined
// until written and need no clearing pass
module roulette_wheel_select_core import rws_pkg::*; #(
	parameter int MAX_POPULATION = 256,
	parameter int RANDOM_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [POP_CNT_W-1:0] cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_POPULATION);
	// room for the sum of every entry at the largest positive fitness
	localparam int SUM_W = 32 + IDX_W;
	localparam int CNT_W = $clog2(MAX_POPULATION + 1);

	wr_bcast_t        wr;
	logic             launch;
	logic             scan;
	logic [SUM_W-1:0] point;
	logic [CNT_W-1:0] cnt;

	// taps between cells; tap 0 is the head of the row
	logic [MAX_POPULATION:0] ch_valid;
	logic [MAX_POPULATION:0] ch_found;
	logic [SUM_W-1:0]        ch_cum [MAX_POPULATION+1];
	logic [IDX_W-1:0]        ch_idx [MAX_POPULATION+1];

	// each wave starts with an empty sum and nothing found
	assign ch_valid[0] = launch;
	assign ch_found[0] = 1'b0;
	assign ch_cum[0]   = '0;
	assign ch_idx[0]   = '0;

	rws_ctrl #(
		.MAX_POPULATION (MAX_POPULATION),
		.RANDOM_BITS    (RANDOM_BITS),
		.IDX_W          (IDX_W),
		.SUM_W          (SUM_W),
		.CNT_W          (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.wr          (wr),
		.launch      (launch),
		.scan        (scan),
		.point       (point),
		.cnt         (cnt),
		.tail_valid  (ch_valid[MAX_POPULATION]),
		.tail_cum    (ch_cum[MAX_POPULATION]),
		.tail_found  (ch_found[MAX_POPULATION]),
		.tail_idx    (ch_idx[MAX_POPULATION])
	);

	// one cell per entry; cells past the population count add nothing to the sum and never set found
	for (genvar g = 0; g < MAX_POPULATION; g++) begin : g_cell
		rws_cell #(
			.IDX   (g),
			.IDX_W (IDX_W),
			.SUM_W (SUM_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr         (wr),
			.scan       (scan),
			.point      (point),
			.cnt        (cnt),
			.prev_valid (ch_valid[g]),
			.prev_cum   (ch_cum[g]),
			.prev_found (ch_found[g]),
			.prev_idx   (ch_idx[g]),
			.valid      (ch_valid[g+1]),
			.cum        (ch_cum[g+1]),
			.found      (ch_found[g+1]),
			.idx        (ch_idx[g+1])
		);
	end

endmodule

// ===== rtl/rws_cell.sv =====
// one fitness chain cell: holds one entry, adds it to the passing sum, marks a scan hit
module rws_cell import rws_pkg::*; #(
	parameter int IDX   = 0,
	parameter int IDX_W = 8,
	parameter int SUM_W = 40,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_bcast_t        wr,
	input  logic             scan,
	input  logic [SUM_W-1:0] point,
	input  logic [CNT_W-1:0] cnt,
	input  logic             prev_valid,
	input  logic [SUM_W-1:0] prev_cum,
	input  logic             prev_found,
	input  logic [IDX_W-1:0] prev_idx,
	output logic             valid,
	output logic [SUM_W-1:0] cum,
	output logic             found,
	output logic [IDX_W-1:0] idx
);

	logic [FIT_W-1:0] fit_q;
	logic             valid_q;
	logic [SUM_W-1:0] cum_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;

	logic [FIT_W-2:0] term;
	logic             active;
	logic [SUM_W-1:0] sum_d;
	logic             hit;

	// non-positive fitness counts as one lsb
	assign term   = (fit_q[FIT_W-1] || fit_q == '0) ? (FIT_W-1)'(1) : fit_q[FIT_W-2:0];
	assign active = (IDX < int'(cnt));
	assign sum_d  = prev_cum + (active ? SUM_W'(term) : '0);
	assign hit    = scan && active && !prev_found && (sum_d >= point);

	always_ff @(posedge clk) begin
		if (wr.en && (int'(wr.idx) == IDX)) begin
			fit_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_valid) begin
			cum_q   <= sum_d;
			found_q <= prev_found || hit;
			idx_q   <= prev_found ? prev_idx : IDX_W'(IDX);
		end
	end

	assign valid = valid_q;
	assign cum   = cum_q;
	assign found = found_q;
	assign idx   = idx_q;

endmodule

// ===== rtl/rws_ctrl.sv =====
// sequencer: handshakes, population count, point scaling and result register
module rws_ctrl import rws_pkg::*; #(
	parameter int MAX_POPULATION = 256,
	parameter int RANDOM_BITS    = 16,
	parameter int IDX_W          = 8,
	parameter int SUM_W          = 40,
	parameter int CNT_W          = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [POP_CNT_W-1:0] cfg_wr_data,
	output wr_bcast_t            wr,
	output logic                 launch,
	output logic                 scan,
	output logic [SUM_W-1:0]     point,
	output logic [CNT_W-1:0]     cnt,
	input  logic                 tail_valid,
	input  logic [SUM_W-1:0]     tail_cum,
	input  logic                 tail_found,
	input  logic [IDX_W-1:0]     tail_idx
);

	localparam int HI_W  = SUM_W - 32;
	localparam int CW    = (CNT_W > POP_CNT_W) ? CNT_W : POP_CNT_W;
	localparam int PLO_W = 32 + RANDOM_BITS;
	localparam int PHI_W = HI_W + RANDOM_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MLO  = 3'd2;
	localparam logic [2:0] ST_MHI  = 3'd3;
	localparam logic [2:0] ST_PNT  = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]             state_q;
	logic [POP_CNT_W-1:0]   pop_count_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [RANDOM_BITS-1:0] frac_q;
	logic [SUM_W-1:0]       total_q;
	logic [PLO_W-1:0]       plo_q;
	logic [PHI_W-1:0]       phi_q;
	logic [SUM_W-1:0]       point_q;
	logic                   launch_q;
	out_item_t              res_q;
	out_item_t              out_q;
	logic                   out_valid_q;

	logic                   in_fire;
	logic                   out_load;
	logic [CW-1:0]          cnt_wide;
	logic [CW-1:0]          cnt_sat;
	logic [SUM_W-1:0]       phi_ext;
	logic [31:0]            plo_sh;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign cnt_wide = CW'(pop_count_q);
	assign cnt_sat  = (cnt_wide > CW'(MAX_POPULATION)) ? CW'(MAX_POPULATION) : cnt_wide;

	// hi part lands whole, lo part loses the fraction bits
	assign phi_ext = SUM_W'(phi_q) << (32 - RANDOM_BITS);
	assign plo_sh  = 32'(plo_q >> RANDOM_BITS);

	assign wr.en   = in_fire && (in_data.kind == KIND_WRITE);
	assign wr.idx  = in_data.entry_index;
	assign wr.data = in_data.fitness_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_count_q <= '0;
		end else if (cfg_wr_en) begin
			pop_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.kind == KIND_SELECT)) begin
						if (cnt_sat == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q  <= ST_SUM;
							launch_q <= 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (tail_valid) begin
						state_q <= ST_MLO;
					end
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_PNT;
				ST_PNT: begin
					state_q  <= ST_SCAN;
					launch_q <= 1'b1;
				end
				ST_SCAN: begin
					if (tail_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_data.kind == KIND_SELECT)) begin
			cnt_q                <= CNT_W'(cnt_sat);
			frac_q               <= RANDOM_BITS'(in_data.random_fraction);
			res_q.selected_index <= '0;
			res_q.empty_error    <= 1'b1;
		end
		if (state_q == ST_SUM && tail_valid) begin
			total_q <= tail_cum;
		end
		if (state_q == ST_MLO) begin
			plo_q <= PLO_W'(total_q[31:0]) * PLO_W'(frac_q);
		end
		if (state_q == ST_MHI) begin
			phi_q <= PHI_W'(total_q[SUM_W-1:32]) * PHI_W'(frac_q);
		end
		if (state_q == ST_PNT) begin
			point_q <= phi_ext + SUM_W'(plo_sh);
		end
		if (state_q == ST_SCAN && tail_valid) begin
			res_q.empty_error <= 1'b0;
			if (tail_found) begin
				res_q.selected_index <= IDX_OUT_W'(tail_idx);
			end else begin
				res_q.selected_index <= IDX_OUT_W'(cnt_q - 1'b1);
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign launch    = launch_q;
	assign scan      = (state_q == ST_SCAN);
	assign point     = point_q;
	assign cnt       = cnt_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the wave only leaves the chain while a pass is running
	a_tail_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !tail_valid)
		else $error("chain wave outside a pass");

	// a result only appears from the done state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done");

	// the scan threshold holds for the whole scan pass
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(state_q) == ST_SCAN) |-> $stable(point_q))
		else $error("point changed during scan");

	// an empty population always reports index zero
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.empty_error) |-> (out_q.selected_index == '0))
		else $error("empty result with nonzero index");

endmodule
